[hw/rtl/assert_macros.svh]
// assertion helpers used by lie_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[hw/rtl/lie_pkg.sv]
// ---------------------------------------------------------------------------
// lie_pkg
// shared constants, status codes and controller/datapath interface structs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lie_pkg;
   localparam int MAX_POINTS_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int STATUS_W       = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

   typedef struct packed {
      logic wr_point;
      logic clr_count;
      logic eval_init;
      logic k_inc;
      logic i_clr;
      logic i_inc;
      logic term_load;
      logic sum_add;
      logic dup_set;
      logic opnd_load;
      logic mul;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic i_eq_count;
      logic i_eq_k;
      logic k_last;
      logic den_zero;
      logic div_last;
   } sts_type;
endpackage
`default_nettype wire

[hw/rtl/lagrange_interpolation_eval_top.sv]
// Lagrange interpolation evaluator. Sample points (x, y) in signed Q16.16 are
// loaded one beat per cycle while idle; points beyond MAX_POINTS are dropped.
// The beat with last_point set closes the set and starts the evaluation at
// the programmed query abscissa, after which one result beat is given and
// the store is emptied. Evaluation runs through the single shared 64-step
// restoring divider, one quotient bit per cycle, for each (k, i) factor; no
// input is taken meanwhile. Status 1 flags duplicate abscissas (value 0),
// status 2 a saturated value. The query register may be written only while
// the block is idle.
// ---------------------------------------------------------------------------
// lagrange_interpolation_eval_top
// top level joining the controller and the datapath
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lagrange_interpolation_eval_top #(
   parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [lie_pkg::DATA_W-1:0]  csr_query_abscissa,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [lie_pkg::DATA_W-1:0]  req_point_x,
   input  wire logic [lie_pkg::DATA_W-1:0]  req_point_y,
   input  wire logic                        req_last_point,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lie_pkg::DATA_W-1:0]       rsp_interp_value,
   output logic [lie_pkg::STATUS_W-1:0]     rsp_status
);
   import lie_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   lie_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   lie_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid && csr_ready),
      .csr_query_abscissa (csr_query_abscissa),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .rsp_interp_value   (rsp_interp_value),
      .rsp_status         (rsp_status),
      .cmd                (cmd),
      .sts                (sts)
   );
endmodule
`default_nettype wire

[hw/rtl/lie_ctrl.sv]
// ---------------------------------------------------------------------------
// lie_ctrl
// sequencer for point loading, term products and the shared divider
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lie_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_last_point,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire lie_pkg::sts_type sts,
   output lie_pkg::cmd_type      cmd
);
   import lie_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_KWAIT = 10'b0000000010,
      S_TLOAD = 10'b0000000100,
      S_IWAIT = 10'b0000001000,
      S_ISTEP = 10'b0000010000,
      S_MUL   = 10'b0000100000,
      S_DIVI  = 10'b0001000000,
      S_DIV   = 10'b0010000000,
      S_DIVF  = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_beat;

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               cmd.wr_point = 1'b1;
               if (req_last_point) begin
                  cmd.eval_init = 1'b1;
                  state_in      = S_KWAIT;
               end
            end
         end
         S_KWAIT: state_in = S_TLOAD;
         S_TLOAD: begin
            cmd.term_load = 1'b1;
            cmd.i_clr     = 1'b1;
            state_in      = S_IWAIT;
         end
         S_IWAIT: state_in = S_ISTEP;
         S_ISTEP: begin
            priority if (sts.i_eq_count) begin
               cmd.sum_add = 1'b1;
               if (sts.k_last) begin
                  state_in = S_FIN;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_KWAIT;
               end
            end else if (sts.i_eq_k || sts.den_zero) begin
               // i equal to k or equal abscissas: skip the divide, flag only the latter
               cmd.dup_set = !sts.i_eq_k;
               cmd.i_inc   = 1'b1;
               state_in    = S_IWAIT;
            end else begin
               cmd.opnd_load = 1'b1;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_DIVF;
         end
         S_DIVF: begin
            cmd.div_finish = 1'b1;
            cmd.i_inc      = 1'b1;
            state_in       = S_IWAIT;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load  = 1'b1;
               cmd.clr_count = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall)       rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_PROP(a_div_len, clock, reset, (state_ff == S_DIVI) |-> ##65 (state_ff == S_DIVF))
   `ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.out_load && rsp_valid_ff && rsp_stall)
   `ASSERT_PROP(a_eval_on_last, clock, reset,
      (state_ff == S_IDLE && !(req_beat && req_last_point)) |=> (state_ff == S_IDLE))
endmodule
`default_nettype wire

[hw/rtl/lie_dp.sv]
// ---------------------------------------------------------------------------
// lie_dp
// point store, product term, restoring divider and wide accumulator with saturated output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lie_dp #(
   parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [lie_pkg::DATA_W-1:0]    csr_query_abscissa,
   input  wire logic [lie_pkg::DATA_W-1:0]    req_point_x,
   input  wire logic [lie_pkg::DATA_W-1:0]    req_point_y,
   output logic [lie_pkg::DATA_W-1:0]         rsp_interp_value,
   output logic [lie_pkg::STATUS_W-1:0]       rsp_status,
   input  wire lie_pkg::cmd_type              cmd,
   output lie_pkg::sts_type                   sts
);
   import lie_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SUM_W = DATA_W + CNT_W + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh7FFFFFFF);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sh80000000);

   logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
   logic signed [DATA_W-1:0] y_mem [MAX_POINTS];

   logic signed [DATA_W-1:0] q_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [IDX_W-1:0]         k_ff;
   logic [CNT_W-1:0]         i_ff;
   logic signed [DATA_W-1:0] xk_rd_ff, xi_rd_ff, yk_rd_ff;
   logic signed [DATA_W-1:0] term_ff, term_in;
   logic signed [DATA_W:0]   num_ff, den_ff, den_w;
   logic signed [63:0]       prod_ff;
   logic signed [64:0]       prod_w;
   logic [63:0]              dvd_ff, p_mag;
   logic [DATA_W:0]          dvs_ff, d_mag, rem_ff;
   logic [DATA_W+1:0]        rem_sh, diff;
   logic                     neg_ff;
   logic [5:0]               step_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     dup_ff, sat_ff, q_sat;
   logic [DATA_W-1:0]        out_val_in;
   logic [STATUS_W-1:0]      out_sts_in;
   logic                     full;

   assign full = (count_ff == CNT_W'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (cmd.wr_point && !full) begin
         x_mem[count_ff[IDX_W-1:0]] <= req_point_x;
         y_mem[count_ff[IDX_W-1:0]] <= req_point_y;
      end
      xk_rd_ff <= x_mem[k_ff];
      yk_rd_ff <= y_mem[k_ff];
      xi_rd_ff <= x_mem[i_ff[IDX_W-1:0]];
   end

   assign den_w = {xk_rd_ff[DATA_W-1], xk_rd_ff} - {xi_rd_ff[DATA_W-1], xi_rd_ff};
   assign prod_w = term_ff * num_ff;

   assign sts.i_eq_count = (i_ff == count_ff);
   assign sts.i_eq_k     = (i_ff == CNT_W'(k_ff));
   assign sts.k_last     = (CNT_W'(k_ff) == count_ff - CNT_W'(1));
   assign sts.den_zero   = (den_w == '0);
   assign sts.div_last   = (step_ff == 6'd63);

   // magnitudes for the restoring divider
   assign p_mag  = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign d_mag  = den_ff[DATA_W] ? (DATA_W+1)'(-den_ff) : (DATA_W+1)'(den_ff);
   assign rem_sh = {rem_ff, dvd_ff[63]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   // signed quotient clipped to 32 bits
   always_comb begin
      term_in = term_ff;
      q_sat   = 1'b0;
      if (!neg_ff) begin
         if (dvd_ff > 64'h7FFF_FFFF) begin
            term_in = 32'sh7FFF_FFFF;
            q_sat   = 1'b1;
         end else begin
            term_in = dvd_ff[DATA_W-1:0];
         end
      end else begin
         if (dvd_ff > 64'h8000_0000) begin
            term_in = 32'sh8000_0000;
            q_sat   = 1'b1;
         end else begin
            term_in = -dvd_ff[DATA_W-1:0];
         end
      end
   end

   always_comb begin
      out_val_in = sum_ff[DATA_W-1:0];
      out_sts_in = sat_ff ? STATUS_SAT : STATUS_OK;
      priority if (dup_ff) begin
         out_val_in = '0;
         out_sts_in = STATUS_DUP;
      end else if (sum_ff > SUM_MAX) begin
         out_val_in = 32'h7FFF_FFFF;
         out_sts_in = STATUS_SAT;
      end else if (sum_ff < SUM_MIN) begin
         out_val_in = 32'h8000_0000;
         out_sts_in = STATUS_SAT;
      end else begin
         out_val_in = sum_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid) q_ff <= csr_query_abscissa;
         priority if (cmd.clr_count)         count_ff <= '0;
         else if (cmd.wr_point && !full)     count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_init) begin
         k_ff   <= '0;
         sum_ff <= '0;
         dup_ff <= 1'b0;
         sat_ff <= 1'b0;
      end
      if (cmd.k_inc) k_ff <= k_ff + IDX_W'(1);
      if (cmd.i_clr) i_ff <= '0;
      if (cmd.i_inc) i_ff <= i_ff + CNT_W'(1);
      if (cmd.term_load) term_ff <= yk_rd_ff;
      if (cmd.sum_add) sum_ff <= sum_ff + SUM_W'(term_ff);
      if (cmd.dup_set) dup_ff <= 1'b1;
      if (cmd.opnd_load) begin
         num_ff <= {q_ff[DATA_W-1], q_ff} - {xi_rd_ff[DATA_W-1], xi_rd_ff};
         den_ff <= den_w;
      end
      if (cmd.mul) prod_ff <= prod_w[63:0];
      if (cmd.div_start) begin
         dvd_ff  <= p_mag;
         dvs_ff  <= d_mag;
         rem_ff  <= '0;
         neg_ff  <= prod_ff[63] ^ den_ff[DATA_W];
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         step_ff <= step_ff + 6'd1;
         if (!diff[DATA_W+1]) begin
            rem_ff <= diff[DATA_W:0];
            dvd_ff <= {dvd_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DATA_W:0];
            dvd_ff <= {dvd_ff[62:0], 1'b0};
         end
      end
      if (cmd.div_finish) begin
         term_ff <= term_in;
         if (q_sat) sat_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         rsp_interp_value <= out_val_in;
         rsp_status       <= out_sts_in;
      end
   end
endmodule
`default_nettype wire
